>>> hdl/sacf_pkg.sv
// Shared constants, codes and a helper function for the set-associative cache simulator.
package sacf_pkg;

  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int ADDR_PORT_W = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_WAYS        = 2'd1,
    CFG_OFFSET_BITS = 2'd2
  } cfg_idx_t;

  // Saturating add of a small increment to a running total.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

>>> hdl/sacf_front.sv
// Front end: configuration registers, command accept and address split into set and tag.
module sacf_front #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             start,
  input  logic                             busy,
  input  logic [1:0]                       in_opcode,
  input  logic [sacf_pkg::ADDR_PORT_W-1:0] in_address,
  output logic                             push,
  output logic [2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH
               + $clog2(MAX_WAYS + 1) - 1:0] push_data
);
  import sacf_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = $clog2(MAX_WAYS + 1);

  typedef struct packed {
    logic [1:0]            op;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag;
    logic [WAY_W-1:0]      ways;
  } req_t;

  logic [CFG_DATA_W-1:0] set_bits_r;
  logic [CFG_DATA_W-1:0] ways_r;
  logic [CFG_DATA_W-1:0] offset_r;

  logic [CFG_DATA_W-1:0] sbits;
  logic [4:0]            ways_clip;
  logic [ADDR_WIDTH-1:0] blk;
  logic [SET_W-1:0]      set_mask;
  req_t                  req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= '0;
      ways_r     <= CFG_DATA_W'(1);
      offset_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_r <= cfg_data;
        CFG_WAYS:        ways_r     <= cfg_data;
        CFG_OFFSET_BITS: offset_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range register values are clipped to what the store can hold.
  always_comb begin
    sbits = (set_bits_r > CFG_DATA_W'(MAX_SET_BITS)) ? CFG_DATA_W'(MAX_SET_BITS)
                                                      : set_bits_r;
    if (ways_r == '0) begin
      ways_clip = 5'd1;
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      ways_clip = 5'(MAX_WAYS);
    end else begin
      ways_clip = {1'b0, ways_r};
    end
    blk          = in_address[ADDR_WIDTH-1:0] >> offset_r;
    set_mask     = ~({SET_W{1'b1}} << sbits);
    req.op       = in_opcode;
    req.set_idx  = blk[SET_W-1:0] & set_mask;
    req.tag      = blk >> sbits;
    req.ways     = WAY_W'(ways_clip);
  end

  assign push      = start & ~busy;
  assign push_data = req;

endmodule

>>> hdl/sacf_fifo.sv
// Small command queue between the front end and the lookup engine.
module sacf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import sacf_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/sacf_back.sv
// Lookup engine: line store, one-way-per-cycle tag search, FIFO victim choice and totals.
module sacf_back #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fifo_empty,
  output logic                         pop,
  input  logic [2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH
               + $clog2(MAX_WAYS + 1) - 1:0] pop_data,
  output logic                         clearing,
  output logic                         out_strobe,
  output logic [1:0]                   out_hits_this_access,
  output logic                         out_miss_flag,
  output logic                         out_evict_flag,
  output logic [sacf_pkg::CNT_W-1:0]   out_hit_total,
  output logic [sacf_pkg::CNT_W-1:0]   out_miss_total,
  output logic [sacf_pkg::CNT_W-1:0]   out_evict_total
);
  import sacf_pkg::*;

  localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W      = $clog2(MAX_WAYS + 1);
  localparam int WI_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int IDX_W      = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int MUL_W      = SET_W + WAY_W;

  typedef struct packed {
    logic [1:0]            op;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag;
    logic [WAY_W-1:0]      ways;
  } req_t;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [CNT_W-1:0]      stamp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  function automatic logic [IDX_W-1:0] line_index(input logic [SET_W-1:0] set_idx,
                                                  input logic [WI_W-1:0]  way);
    logic [MUL_W-1:0] sum;
    sum = MUL_W'(set_idx) * MUL_W'(MAX_WAYS) + MUL_W'(way);
    return sum[IDX_W-1:0];
  endfunction

  entry_t mem [LINE_COUNT];
  entry_t rd_data_r;

  state_t           state_r;
  req_t             cur_r;
  req_t             pop_req;
  logic [WI_W-1:0]  chk_w_r;
  logic [WI_W-1:0]  victim_r;
  logic [CNT_W-1:0] best_age_r;
  logic             hit_r;
  logic             empty_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic [CNT_W-1:0] acc_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] evict_cnt_r;

  logic             out_strobe_r;
  logic [1:0]       out_hits_r;
  logic             out_miss_r;
  logic             out_evict_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] mem_ra;

  logic [CNT_W-1:0] age;
  logic             look_empty;
  logic             look_hit;
  logic             look_last;
  logic             take_age;
  logic [1:0]       hits;
  logic             evict;
  logic [CNT_W-1:0] hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_nxt;
  logic [CNT_W-1:0] evict_cnt_nxt;

  assign pop_req  = pop_data;
  assign pop      = (state_r == ST_IDLE) && !fifo_empty;
  assign clearing = (state_r == ST_CLEAR);

  // Valid ways of a set are contiguous, so ways before the one in hand were all
  // valid misses and the first examined way always seeds the oldest-fill search.
  always_comb begin
    age        = acc_r - rd_data_r.stamp;
    look_empty = !rd_data_r.valid;
    look_hit   = rd_data_r.valid && (rd_data_r.tag == cur_r.tag);
    look_last  = (WAY_W'(chk_w_r) + WAY_W'(1)) == cur_r.ways;
    take_age   = (chk_w_r == '0) || (age >= best_age_r);
    hits       = {1'b0, hit_r} + {1'b0, cur_r.op == OP_MODIFY};
    evict      = !hit_r && !empty_r;
    hit_cnt_nxt   = sat_add(hit_cnt_r, hits);
    miss_cnt_nxt  = hit_r ? miss_cnt_r : sat_add(miss_cnt_r, 2'd1);
    evict_cnt_nxt = evict ? sat_add(evict_cnt_r, 2'd1) : evict_cnt_r;
  end

  // The next way is read while the current one is examined; a read past the
  // end of the search is simply dropped.
  always_comb begin
    if (state_r == ST_IDLE) begin
      mem_ra = line_index(pop_req.set_idx, '0);
    end else begin
      mem_ra = line_index(cur_r.set_idx, chk_w_r + WI_W'(1));
    end
    mem_we = 1'b0;
    mem_wa = clr_idx_r;
    mem_wd = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_DONE && !hit_r) begin
      mem_we       = 1'b1;
      mem_wa       = line_index(cur_r.set_idx, victim_r);
      mem_wd.valid = 1'b1;
      mem_wd.tag   = cur_r.tag;
      mem_wd.stamp = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      acc_r        <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == IDX_W'(LINE_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!fifo_empty) begin
            cur_r   <= pop_req;
            chk_w_r <= '0;
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (look_empty) begin
            hit_r    <= 1'b0;
            empty_r  <= 1'b1;
            victim_r <= chk_w_r;
            state_r  <= ST_DONE;
          end else if (look_hit) begin
            hit_r   <= 1'b1;
            empty_r <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            if (take_age) begin
              best_age_r <= age;
              victim_r   <= chk_w_r;
            end
            if (look_last) begin
              hit_r   <= 1'b0;
              empty_r <= 1'b0;
              state_r <= ST_DONE;
            end else begin
              chk_w_r <= chk_w_r + WI_W'(1);
            end
          end
        end
        ST_DONE: begin
          hit_cnt_r    <= hit_cnt_nxt;
          miss_cnt_r   <= miss_cnt_nxt;
          evict_cnt_r  <= evict_cnt_nxt;
          acc_r        <= acc_r + CNT_W'(1);
          out_strobe_r <= 1'b1;
          out_hits_r   <= hits;
          out_miss_r   <= !hit_r;
          out_evict_r  <= evict;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_hits_this_access = out_hits_r;
  assign out_miss_flag        = out_miss_r;
  assign out_evict_flag       = out_evict_r;
  assign out_hit_total        = hit_cnt_r;
  assign out_miss_total       = miss_cnt_r;
  assign out_evict_total      = evict_cnt_r;

endmodule

>>> hdl/set_assoc_cache_sim_fifo.sv
// Top level of the set-associative cache hit/miss simulator with FIFO replacement.
//
// Each command word (load, store or modify plus a byte address) is taken when
// start is high and busy is low. The front end splits the address into set and
// tag with the configured block offset and set index bit counts and places the
// command in a two-entry queue. The lookup engine then examines the ways of the
// set one per cycle from a line store with one read and one write port,
// stopping at a tag match or the first empty way, and on a miss fills that
// empty way or replaces the way filled longest ago. An access passes through
// the idle state, which starts the first read, the look state, which examines
// the ways up to the number in use, and the done state, which writes the line
// back and updates the totals. The result word appears on the out_ ports in the
// following cycle for exactly one cycle, flagged by out_strobe; the receiver
// cannot stall it, so it must capture every strobed word. Thanks to the queue,
// new commands are taken while the engine is still working, and outside the
// clearing pass busy rises only when the queue is full. After reset the line
// store is cleared one entry per cycle, and busy stays high until that pass
// ends; configuration writes are taken at any time but should only be issued
// while no command is outstanding. Hit, miss and eviction totals saturate at
// 2**32-1.
module set_assoc_cache_sim_fifo #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_opcode,
  input  logic [sacf_pkg::ADDR_PORT_W-1:0] in_address,
  output logic                             out_strobe,
  output logic [1:0]                       out_hits_this_access,
  output logic                             out_miss_flag,
  output logic                             out_evict_flag,
  output logic [sacf_pkg::CNT_W-1:0]       out_hit_total,
  output logic [sacf_pkg::CNT_W-1:0]       out_miss_total,
  output logic [sacf_pkg::CNT_W-1:0]       out_evict_total
);
  import sacf_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = $clog2(MAX_WAYS + 1);
  localparam int REQ_W = 2 + SET_W + ADDR_WIDTH + WAY_W;

  logic             q_push;
  logic [REQ_W-1:0] q_push_data;
  logic             q_pop;
  logic [REQ_W-1:0] q_pop_data;
  logic             q_full;
  logic             q_empty;
  logic             clearing;

  // Commands are held off while the store is being cleared or the queue is full.
  assign busy = q_full | clearing;

  sacf_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_address (in_address),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  sacf_fifo #(
    .WIDTH (REQ_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sacf_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fifo_empty           (q_empty),
    .pop                  (q_pop),
    .pop_data             (q_pop_data),
    .clearing             (clearing),
    .out_strobe           (out_strobe),
    .out_hits_this_access (out_hits_this_access),
    .out_miss_flag        (out_miss_flag),
    .out_evict_flag       (out_evict_flag),
    .out_hit_total        (out_hit_total),
    .out_miss_total       (out_miss_total),
    .out_evict_total      (out_evict_total)
  );

  // The engine passes through the idle, look and done states for every access, so result words never abut.
  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobes on consecutive cycles");

  // A miss contributes no lookup hit and a hit always contributes one.
  a_hits_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_miss_flag ? (out_hits_this_access != 2'd2)
                                  : (out_hits_this_access != 2'd0)))
    else $error("hit count disagrees with miss flag");

  // Only a miss can replace a line.
  a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_evict_flag) |-> out_miss_flag)
    else $error("eviction reported on a hit");

  // Reset starts the store clearing pass, which must hold commands off.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("commands accepted before the store was cleared");

endmodule

>>> bench/set_assoc_cache_sim_fifo_tb.sv
// Self-checking testbench for the set-associative cache simulator with FIFO replacement.
module set_assoc_cache_sim_fifo_tb;
  import sacf_pkg::*;

  // Geometry of the instance; the bench's own copy of the line store uses the same layout.
  localparam int SET_BITS_MAX = 8;
  localparam int WAYS_MAX     = 8;
  localparam int ADDR_BITS    = 64;
  localparam int LINE_TOTAL   = (1 << SET_BITS_MAX) * WAYS_MAX;

  // The opcode field has one code beyond modify; the block treats it as a plain load.
  localparam logic [1:0] OP_AS_LOAD = 2'd3;
  // The index field can name a fourth register that does not exist.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // The clearing pass after reset keeps busy high while it clears all LINE_TOTAL lines,
  // so the watchdog limit sits well above the length of that pass. A word otherwise
  // waits only for the engine and the longest sender gap.
  localparam int QUIET_LIMIT   = 10000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 70;
  localparam int MAX_PRINTS    = 40;

  typedef struct packed {
    logic [1:0]       hits;
    logic             miss;
    logic             evict;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } lookup_result_t;

  // One row of the directed sequence: either a register write or a command word,
  // optionally with its result typed in by hand.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [1:0]            op;
    logic [63:0]           addr;
    bit                    typed;
    lookup_result_t        want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_opcode;
  logic [ADDR_PORT_W-1:0] in_address;
  logic                   out_strobe;
  logic [1:0]             out_hits_this_access;
  logic                   out_miss_flag;
  logic                   out_evict_flag;
  logic [CNT_W-1:0]       out_hit_total;
  logic [CNT_W-1:0]       out_miss_total;
  logic [CNT_W-1:0]       out_evict_total;

  set_assoc_cache_sim_fifo #(
    .MAX_SET_BITS(SET_BITS_MAX),
    .MAX_WAYS    (WAYS_MAX),
    .ADDR_WIDTH  (ADDR_BITS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .out_strobe          (out_strobe),
    .out_hits_this_access(out_hits_this_access),
    .out_miss_flag       (out_miss_flag),
    .out_evict_flag      (out_evict_flag),
    .out_hit_total       (out_hit_total),
    .out_miss_total      (out_miss_total),
    .out_evict_total     (out_evict_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the cache: tags, valid bits, fill stamps, the access count and
  // the three saturating totals, plus the register values as last written.
  logic [63:0]           shadow_tag   [LINE_TOTAL];
  bit                    shadow_valid [LINE_TOTAL];
  logic [31:0]           shadow_stamp [LINE_TOTAL];
  logic [31:0]           access_count = '0;
  logic [CNT_W-1:0]      hit_sum      = '0;
  logic [CNT_W-1:0]      miss_sum     = '0;
  logic [CNT_W-1:0]      evict_sum    = '0;
  logic [CFG_DATA_W-1:0] shadow_set_bits    = 4'd0;
  logic [CFG_DATA_W-1:0] shadow_ways        = 4'd1;
  logic [CFG_DATA_W-1:0] shadow_offset_bits = 4'd0;

  lookup_result_t pending_lookups[$];
  plan_row_t      directed_plan[$];
  logic [63:0]    hot_blocks[$];

  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned words_seen   = 0;
  int unsigned reg_writes   = 0;
  int unsigned misses_seen  = 0;
  int unsigned evicts_seen  = 0;
  bit          no_gaps      = 1'b0;

  initial begin
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
  end

  // Totals stop at all ones instead of wrapping.
  function automatic logic [CNT_W-1:0] bump_total(input logic [CNT_W-1:0] total,
                                                  input logic [1:0] inc);
    if (total > {CNT_W{1'b1}} - CNT_W'(inc)) return {CNT_W{1'b1}};
    return total + CNT_W'(inc);
  endfunction

  // Looks one access up in the shadow cache, applies the fill or replacement, and
  // returns the result word the block should produce for it.
  function automatic lookup_result_t predict_lookup(input logic [1:0] op,
                                                    input logic [63:0] addr);
    int unsigned    sbits, ways, set_idx, base, victim, e;
    logic [31:0]    age, best_age;
    logic [63:0]    blk, tag;
    bit             hit, found_empty, have_best;
    lookup_result_t r;
    sbits = (shadow_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : shadow_set_bits;
    ways  = (shadow_ways == 0) ? 1 : shadow_ways;
    if (ways > WAYS_MAX) ways = WAYS_MAX;
    blk     = addr >> shadow_offset_bits;
    set_idx = int'(blk & ((64'd1 << sbits) - 64'd1));
    tag     = blk >> sbits;
    base    = set_idx * WAYS_MAX;
    hit = 1'b0;
    found_empty = 1'b0;
    have_best = 1'b0;
    victim = 0;
    best_age = '0;
    // Valid ways are packed from way zero, so the first empty way ends the search.
    // Among full ways the one with the largest age (count minus stamp) is the oldest
    // fill; a tie goes to the higher way.
    for (int unsigned w = 0; w < ways; w++) begin
      e = base + w;
      if (!shadow_valid[e]) begin
        found_empty = 1'b1;
        victim = w;
        break;
      end
      if (shadow_tag[e] == tag) begin
        hit = 1'b1;
        break;
      end
      age = access_count - shadow_stamp[e];
      if (!have_best || age >= best_age) begin
        best_age  = age;
        victim    = w;
        have_best = 1'b1;
      end
    end
    r = '0;
    r.hits  = hit ? 2'd1 : 2'd0;
    r.miss  = !hit;
    r.evict = !hit && !found_empty;
    if (!hit) begin
      // Stamps change only on a fill, which is what makes the policy FIFO.
      e = base + victim;
      shadow_tag[e]   = tag;
      shadow_valid[e] = 1'b1;
      shadow_stamp[e] = access_count;
      miss_sum = bump_total(miss_sum, 2'd1);
      if (r.evict) evict_sum = bump_total(evict_sum, 2'd1);
    end
    if (op == OP_MODIFY) r.hits = r.hits + 2'd1;
    hit_sum = bump_total(hit_sum, r.hits);
    access_count = access_count + 32'd1;
    r.hit_total   = hit_sum;
    r.miss_total  = miss_sum;
    r.evict_total = evict_sum;
    return r;
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_word(input logic [1:0] op, input logic [63:0] addr);
    plan_row_t row;
    row = '{default: '0};
    row.op   = op;
    row.addr = addr;
    directed_plan.push_back(row);
  endfunction

  // A command word whose result is obvious enough to be written down directly.
  function automatic void plan_known(input logic [1:0] op, input logic [63:0] addr,
                                     input logic [1:0] hits, input bit miss,
                                     input bit evict, input int unsigned hit_tot,
                                     input int unsigned miss_tot,
                                     input int unsigned evict_tot);
    plan_row_t row;
    row = '{default: '0};
    row.op    = op;
    row.addr  = addr;
    row.typed = 1'b1;
    row.want  = '{hits, miss, evict, hit_tot, miss_tot, evict_tot};
    directed_plan.push_back(row);
  endfunction

  // Sender gaps: mostly none or a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Drives one command word and holds it until the block takes it. The expected
  // result is computed at acceptance, when the register values are settled.
  task automatic send_word(input logic [1:0] op, input logic [63:0] addr,
                           input bit typed, input lookup_result_t want);
    int unsigned    gap;
    lookup_result_t predicted;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_opcode  <= op;
    in_address <= addr;
    do @(posedge clk); while (busy);
    predicted = predict_lookup(op, addr);
    pending_lookups.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Drops start and waits until every expected result word has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SET_BITS:    shadow_set_bits    = val;
      CFG_WAYS:        shadow_ways        = val;
      CFG_OFFSET_BITS: shadow_offset_bits = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Builds a small set of block addresses for a phase. They fall into at most four
  // sets and outnumber the ways, so repeats give hits and the overflow forces
  // replacements.
  task automatic build_hot_blocks();
    int unsigned sbits, ways, sets, set_sel;
    logic [63:0] tag;
    sbits = (shadow_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : shadow_set_bits;
    ways  = (shadow_ways == 0) ? 1 : ((shadow_ways > WAYS_MAX) ? WAYS_MAX : shadow_ways);
    sets  = 1 << sbits;
    hot_blocks.delete();
    repeat (2 * ways + 2) begin
      tag     = {$urandom, $urandom};
      set_sel = $urandom_range(0, (sets > 4) ? 3 : sets - 1);
      hot_blocks.push_back((tag << (shadow_offset_bits + sbits)) |
                           (64'(set_sel) << shadow_offset_bits));
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string name, input int unsigned idx,
                               input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0d, expected %0d", idx, name, got, want));
  endtask

  // Result words last one cycle and cannot be held off, so each strobe is checked
  // at the edge that ends it. The same process keeps the watchdog count: any word
  // moving on any channel counts as progress.
  always @(posedge clk) begin
    lookup_result_t want;
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_strobe) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  words_seen));
      end else begin
        want = pending_lookups.pop_front();
        compare_field("hits_this_access", words_seen, 32'(out_hits_this_access),
                      32'(want.hits));
        compare_field("miss_flag", words_seen, 32'(out_miss_flag), 32'(want.miss));
        compare_field("evict_flag", words_seen, 32'(out_evict_flag), 32'(want.evict));
        compare_field("hit_total", words_seen, out_hit_total, want.hit_total);
        compare_field("miss_total", words_seen, out_miss_total, want.miss_total);
        compare_field("evict_total", words_seen, out_evict_total, want.evict_total);
      end
      if (out_miss_flag === 1'b1) misses_seen++;
      if (out_evict_flag === 1'b1) evicts_seen++;
      words_seen++;
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with no word moving", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] sb, wy, ob;
    logic [1:0]            op;
    logic [63:0]           addr, offset_mask;
    int unsigned           pick;

    rst_n      = 1'b0;
    start      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SET_BITS;
    cfg_data   = '0;
    in_opcode  = OP_LOAD;
    in_address = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. With the reset split there is one set of one way, so the first
    // six results follow by hand: a cold miss, a hit, a modify hit worth two, a store
    // to the all-ones address that replaces the only line, a modify that misses and
    // still gets its extra hit, and the spare opcode acting as a plain load.
    plan_known(OP_LOAD,    64'h0, 2'd0, 1'b1, 1'b0, 0, 1, 0);
    plan_known(OP_LOAD,    64'h0, 2'd1, 1'b0, 1'b0, 1, 1, 0);
    plan_known(OP_MODIFY,  64'h0, 2'd2, 1'b0, 1'b0, 3, 1, 0);
    plan_known(OP_STORE,   '1,    2'd0, 1'b1, 1'b1, 3, 2, 1);
    plan_known(OP_MODIFY,  64'h0, 2'd1, 1'b1, 1'b1, 4, 3, 2);
    plan_known(OP_AS_LOAD, 64'h0, 2'd1, 1'b0, 1'b0, 5, 3, 2);
    // Zero ways behaves as one way, so a new tag replaces the line.
    plan_cfg(CFG_WAYS, 4'd0);
    plan_word(OP_LOAD, 64'h1);
    // A write to the unused index must change nothing.
    plan_cfg(CFG_NO_REG, 4'hF);
    // Every register at its top code: set bits and ways clamp to the instance
    // maximum, the offset of 15 is used as written.
    plan_cfg(CFG_SET_BITS, 4'hF);
    plan_cfg(CFG_WAYS, 4'hF);
    plan_cfg(CFG_OFFSET_BITS, 4'hF);
    // Lines survive a change of split: this address now maps to set 0 with tag 1,
    // which is exactly the line the earlier load left behind.
    plan_word(OP_LOAD, 64'h80_0000);
    // Seven more tags fill the set and the eighth pushes out the oldest fill; the
    // tag that was just pushed out then misses again and pushes out the next one.
    for (int i = 2; i <= 9; i++) plan_word(OP_LOAD, 64'(i) << 23);
    plan_word(OP_LOAD, 64'h1 << 23);
    plan_word(OP_MODIFY, (64'h3 << 23) | 64'h7FFF);
    plan_word(OP_STORE, 64'h8000_0000_007F_8000);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_word(directed_plan[i].op, directed_plan[i].addr, directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    // Random part: a run of phases, each with its own register values. The first
    // four pin the extremes; the rest draw every register over its full four-bit
    // code. Every third phase runs with no gaps from the sender.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       {sb, wy, ob} = {4'd0, 4'd1, 4'd0};
        1:       {sb, wy, ob} = {4'd8, 4'd8, 4'd9};
        2:       {sb, wy, ob} = {4'd15, 4'd15, 4'd15};
        3:       {sb, wy, ob} = {4'd1, 4'd0, 4'd3};
        default: {sb, wy, ob} = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                 4'($urandom_range(0, 15))};
      endcase
      drain();
      write_reg(CFG_SET_BITS, sb);
      write_reg(CFG_WAYS, wy);
      write_reg(CFG_OFFSET_BITS, ob);
      no_gaps = (p % 3 == 1);
      build_hot_blocks();
      offset_mask = (64'd1 << shadow_offset_bits) - 64'd1;
      repeat (PHASE_WORDS) begin
        // Most words reuse the hot blocks with a random byte offset inside the
        // block; the rest are fully random addresses that toggle every bit.
        pick = $urandom_range(0, 99);
        if (pick < 85)
          addr = hot_blocks[$urandom_range(0, hot_blocks.size() - 1)] |
                 ({$urandom, $urandom} & offset_mask);
        else
          addr = {$urandom, $urandom};
        op = ($urandom_range(0, 9) == 0) ? OP_AS_LOAD : 2'($urandom_range(0, 2));
        send_word(op, addr, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;
    drain();

    $display("Sent %0d command words under %0d register writes across %0d phases.",
             words_sent, reg_writes, PHASES);
    $display("Checked %0d result words: %0d misses, %0d replacements.",
             words_seen, misses_seen, evicts_seen);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
